// ----- src/tlik_pkg.sv -----
// Shared types, constants and tables for the two-link inverse kinematics unit.
`timescale 1ns / 1ps

package tlik_pkg;

	// Default parameter values for the top level.
	localparam int DEF_COORD_WIDTH     = 16;
	localparam int DEF_ANGLE_FRAC_BITS = 12;

	// Fixed field widths.
	localparam int LINK_WIDTH  = 14;
	localparam int CFG_WIDTH   = 16;
	localparam int ANGLE_WIDTH = 16;

	// Internal angle format: Q30 radians in a signed word wide enough for pi plus headroom.
	localparam int QI           = 30;
	localparam int ZW           = 36;
	localparam int CORDIC_STEPS = 30;

	localparam logic signed [ZW-1:0] PI_Q = 36'sd3373259426;
	localparam logic [63:0] ONE_SQ = 64'd1 << 60;

	// Arctangent of 2^-i in Q30 radians.
	localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
		36'sd33543516, 36'sd16775851, 36'sd8388437, 36'sd4194283, 36'sd2097149,
		36'sd1048576, 36'sd524288, 36'sd262144, 36'sd131072, 36'sd65536,
		36'sd32768, 36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048,
		36'sd1024, 36'sd512, 36'sd256, 36'sd128, 36'sd64,
		36'sd32, 36'sd16, 36'sd8, 36'sd4, 36'sd2
	};

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_LINK_ONE    = 3'd0,
		CFG_LINK_TWO    = 3'd1,
		CFG_OFFSET_X    = 3'd2,
		CFG_OFFSET_Y    = 3'd3,
		CFG_SHOULDER_LO = 3'd4,
		CFG_SHOULDER_HI = 3'd5,
		CFG_ELBOW_LO    = 3'd6,
		CFG_ELBOW_HI    = 3'd7
	} cfg_idx_t;

	// Register reset values.
	localparam logic [LINK_WIDTH-1:0]        RST_LINK      = 14'd1600;
	localparam logic signed [CFG_WIDTH-1:0]  RST_ANGLE_MIN = -16'sd19303;
	localparam logic signed [CFG_WIDTH-1:0]  RST_ANGLE_MAX = 16'sd19303;

endpackage

// ----- src/two_link_inverse_kinematics_unit.sv -----
// Fully pipelined two-link planar arm inverse kinematics unit.
`timescale 1ns / 1ps

// The unit takes one target point per clock unless held and returns the shoulder and
// elbow angles in input order. Its depth comes from the bit-serial stages: a 31-step
// divider for the cosine term, a 32-step square root for the sine, a 32-step divider
// for the sine ratio, another square root and a 30-step CORDIC, each step one register
// stage. Three CORDIC and three square root units run as separate pipelines. All stages
// advance together; when a finished result is not taken, the whole pipeline holds and
// target_ready drops until the result leaves. Configuration registers are written
// through cfg_write, cfg_index and cfg_data, by the user only while the unit is idle.
module two_link_inverse_kinematics_unit #(
	parameter int COORD_WIDTH     = tlik_pkg::DEF_COORD_WIDTH,
	parameter int ANGLE_FRAC_BITS = tlik_pkg::DEF_ANGLE_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [2:0]                           cfg_index,
	input  logic [tlik_pkg::CFG_WIDTH-1:0]       cfg_data,
	input  logic                                 target_valid,
	output logic                                 target_ready,
	input  logic signed [COORD_WIDTH-1:0]        target_x,
	input  logic signed [COORD_WIDTH-1:0]        target_y,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [tlik_pkg::ANGLE_WIDTH-1:0] shoulder_angle,
	output logic signed [tlik_pkg::ANGLE_WIDTH-1:0] elbow_angle,
	output logic                                 out_of_reach,
	output logic                                 shoulder_clamped,
	output logic                                 elbow_clamped
);

	localparam int XW  = COORD_WIDTH + 1;
	localparam int PW  = 2 * XW;
	localparam int CDW = ((COORD_WIDTH > 30) ? COORD_WIDTH : 30) + 5;
	localparam int ZW  = tlik_pkg::ZW;
	localparam int OW  = ZW + 2;
	localparam int RS  = tlik_pkg::QI - ANGLE_FRAC_BITS;
	localparam int LW  = tlik_pkg::LINK_WIDTH;
	localparam int NS  = tlik_pkg::CORDIC_STEPS;

	// Stage numbers of the main events.
	localparam int T_M    = 4;
	localparam int T_C    = T_M + 32;
	localparam int T_SV   = T_C + 2;
	localparam int T_SB   = T_SV + 32;
	localparam int T_BETA = T_SB + 33;
	localparam int T_DQ   = T_M + 1 + 32;
	localparam int T_NU   = T_SB + 2;
	localparam int T_U    = T_NU + 1 + 31 + 1;
	localparam int T_W    = T_U + 2 + 32;
	localparam int T_G    = T_W + 33;
	localparam int T_TH   = 1 + 33;
	localparam int T_OUT  = T_G + 3;

	// Delay line lengths that align side values with the main chain.
	localparam int D_NS  = T_C - 1 - T_M;
	localparam int D_C   = T_SB - T_C;
	localparam int D_K   = T_SB + 1 - T_M;
	localparam int D_DQ  = T_NU - T_DQ;
	localparam int D_U   = T_W - T_U;
	localparam int D_TH  = T_G - T_TH;
	localparam int D_BT  = T_G - T_BETA;
	localparam int D_ZD  = T_G - T_M;
	localparam int D_RF  = T_OUT - 1 - T_M;

	// Pipeline control: every stage moves when the output stage is empty or taken.
	logic [T_OUT:1] vld;
	logic           en;

	assign en           = !vld[T_OUT] || result_ready;
	assign target_ready = en;
	assign result_valid = vld[T_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[T_OUT-1:1], target_valid};
		end
	end

	// Configuration registers.
	logic [LW-1:0]        l1_q, l2_q;
	logic [15:0]          offx_q, offy_q;
	logic signed [15:0]   sh_min_q, sh_max_q, el_min_q, el_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q     <= tlik_pkg::RST_LINK;
			l2_q     <= tlik_pkg::RST_LINK;
			offx_q   <= '0;
			offy_q   <= '0;
			sh_min_q <= tlik_pkg::RST_ANGLE_MIN;
			sh_max_q <= tlik_pkg::RST_ANGLE_MAX;
			el_min_q <= tlik_pkg::RST_ANGLE_MIN;
			el_max_q <= tlik_pkg::RST_ANGLE_MAX;
		end else if (cfg_write) begin
			case (tlik_pkg::cfg_idx_t'(cfg_index))
				tlik_pkg::CFG_LINK_ONE:    l1_q     <= cfg_data[LW-1:0];
				tlik_pkg::CFG_LINK_TWO:    l2_q     <= cfg_data[LW-1:0];
				tlik_pkg::CFG_OFFSET_X:    offx_q   <= cfg_data;
				tlik_pkg::CFG_OFFSET_Y:    offy_q   <= cfg_data;
				tlik_pkg::CFG_SHOULDER_LO: sh_min_q <= cfg_data;
				tlik_pkg::CFG_SHOULDER_HI: sh_max_q <= cfg_data;
				tlik_pkg::CFG_ELBOW_LO:    el_min_q <= cfg_data;
				tlik_pkg::CFG_ELBOW_HI:    el_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Link-derived constants, recomputed from the registers every cycle.
	logic [27:0] l11, l22, l12;
	logic [28:0] ls_q, den_q;
	logic [29:0] den_half;

	assign l11      = l1_q * l1_q;
	assign l22      = l2_q * l2_q;
	assign l12      = l1_q * l2_q;
	assign den_half = {2'b00, den_q[28:1]};

	always_ff @(posedge clk) begin
		ls_q  <= {1'b0, l11} + {1'b0, l22};
		den_q <= {l12, 1'b0};
	end

	// Base offsets seen at the coordinate width.
	logic signed [COORD_WIDTH-1:0] offx_cw, offy_cw;

	generate
		if (COORD_WIDTH <= 16) begin : g_off_narrow
			assign offx_cw = offx_q[COORD_WIDTH-1:0];
			assign offy_cw = offy_q[COORD_WIDTH-1:0];
		end else begin : g_off_wide
			assign offx_cw = {{(COORD_WIDTH-16){1'b0}}, offx_q};
			assign offy_cw = {{(COORD_WIDTH-16){1'b0}}, offy_q};
		end
	endgenerate

	// Unit ports: three square roots and three CORDIC vectoring units.
	logic [63:0]             sq_in [3];
	logic [31:0]             sq_out [3];
	logic signed [CDW-1:0]   cin_x [3];
	logic signed [CDW-1:0]   cin_y [3];
	logic signed [ZW-1:0]    cz [3];

	// Stage 1: shoulder frame point.
	logic signed [XW-1:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= XW'(target_x) + XW'(offx_cw);
			y_s1 <= XW'(target_y) + XW'(offy_cw);
		end
	end

	// Stage 2: squared coordinates, wrapped to 64 bits.
	logic [XW-1:0] ax1, ay1;
	logic [PW-1:0] sqx, sqy;
	logic [63:0]   sqx_s2, sqy_s2;

	assign ax1 = x_s1[XW-1] ? XW'(-x_s1) : x_s1;
	assign ay1 = y_s1[XW-1] ? XW'(-y_s1) : y_s1;
	assign sqx = ax1 * ax1;
	assign sqy = ay1 * ay1;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= 64'(sqx);
			sqy_s2 <= 64'(sqy);
		end
	end

	// Stage 3: squared distance.
	logic [63:0] d2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3 <= sqx_s2 + sqy_s2;
		end
	end

	// Stage 4: cosine numerator, saturation and the distance prescale.
	logic [63:0] ls64, m_full;
	logic        neg_c, sat_c;
	logic [3:0]  k_c;
	logic [28:0] m_s4;
	logic        neg_s4, sat_s4, zd_s4;
	logic [3:0]  k_s4;
	logic [63:0] d2_s4;

	assign ls64 = {35'd0, ls_q};

	always_comb begin
		neg_c  = ls64 < d2_s3;
		m_full = neg_c ? d2_s3 - ls64 : ls64 - d2_s3;
		sat_c  = (den_q == '0) || (m_full > {35'd0, den_q});
		k_c    = '0;
		for (int k = 0; k < 16; k++) begin
			if ((d2_s3 >> (62 - 2 * k)) == 64'd0) begin
				k_c = 4'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4   <= m_full[28:0];
			neg_s4 <= neg_c;
			sat_s4 <= sat_c;
			zd_s4  <= (d2_s3 == 64'd0);
			k_s4   <= k_c;
			d2_s4  <= d2_s3;
		end
	end

	// Stage 5: prescaled squared distance for the distance square root.
	logic [63:0] d2s_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			d2s_s5 <= d2_s4 << {k_s4, 1'b0};
		end
	end

	assign sq_in[0] = d2s_s5;

	// Cosine divider: round(m * 2^30 / den), one quotient bit per stage.
	logic [28:0] crem_s [0:30];
	logic [30:0] cq_s [0:30];

	always_ff @(posedge clk) begin
		if (en) begin
			if (m_s4 >= den_q) begin
				crem_s[0] <= m_s4 - den_q;
				cq_s[0]   <= 31'd1;
			end else begin
				crem_s[0] <= m_s4;
				cq_s[0]   <= 31'd0;
			end
		end
	end

	genvar gj;
	generate
		for (gj = 0; gj < 30; gj++) begin : g_cdiv
			logic [29:0] t;

			assign t = {crem_s[gj], den_half[29-gj]};

			always_ff @(posedge clk) begin
				if (en) begin
					if (t >= {1'b0, den_q}) begin
						crem_s[gj+1] <= 29'(t - {1'b0, den_q});
						cq_s[gj+1]   <= {cq_s[gj][29:0], 1'b1};
					end else begin
						crem_s[gj+1] <= t[28:0];
						cq_s[gj+1]   <= {cq_s[gj][29:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	// Sign and saturation follow the divider.
	logic neg_s [1:D_NS];
	logic sat_s [1:D_NS];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[1] <= neg_s4;
			sat_s[1] <= sat_s4;
			for (int i = 2; i <= D_NS; i++) begin
				neg_s[i] <= neg_s[i-1];
				sat_s[i] <= sat_s[i-1];
			end
		end
	end

	// Signed cosine term.
	logic signed [31:0] c_sc;
	logic signed [31:0] c_sel;

	always_comb begin
		if (sat_s[D_NS]) begin
			c_sel = 32'sd1 <<< 30;
		end else begin
			c_sel = signed'({1'b0, cq_s[30]});
		end
		if (neg_s[D_NS]) begin
			c_sel = -c_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_sc <= c_sel;
		end
	end

	// Squared cosine, then the square root operand 1 - c^2.
	logic [30:0] cmag;
	logic [61:0] csq_s, csq_p;
	logic [63:0] sv_s;

	assign cmag  = c_sc[31] ? 31'(-c_sc) : c_sc[30:0];
	assign csq_p = cmag * cmag;

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s <= csq_p;
			sv_s  <= tlik_pkg::ONE_SQ - 64'(csq_s);
		end
	end

	assign sq_in[1] = sv_s;

	// Cosine waits for the sine.
	logic signed [31:0] c_d [1:D_C];

	always_ff @(posedge clk) begin
		if (en) begin
			c_d[1] <= c_sc;
			for (int i = 2; i <= D_C; i++) begin
				c_d[i] <= c_d[i-1];
			end
		end
	end

	logic [30:0] sb;

	assign sb       = sq_out[1][30:0];
	assign cin_y[1] = CDW'(signed'({1'b0, sb}));
	assign cin_x[1] = CDW'(c_d[D_C]);

	// Prescale exponent and distance follow to the sine ratio.
	logic [3:0]  k_d [1:D_K];
	logic [31:0] dq_d [1:D_DQ];

	always_ff @(posedge clk) begin
		if (en) begin
			k_d[1]  <= k_s4;
			dq_d[1] <= sq_out[0];
			for (int i = 2; i <= D_K; i++) begin
				k_d[i] <= k_d[i-1];
			end
			for (int i = 2; i <= D_DQ; i++) begin
				dq_d[i] <= dq_d[i-1];
			end
		end
	end

	// Sine ratio numerator: sin(beta) * L2 * 2^k.
	logic [44:0] p_s;
	logic [59:0] nu_s;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s  <= sb * l2_q;
			nu_s <= 60'(p_s) << k_d[D_K];
		end
	end

	// Sine ratio divider, with overflow detection at 2^31 and above.
	logic [30:0] urem_s [0:31];
	logic [30:0] uq_s [0:31];
	logic [30:0] unl_s [0:31];
	logic [31:0] udq_s [0:31];
	logic        uov_s [0:31];
	logic        ov0;

	assign ov0 = {3'b000, nu_s[59:31]} >= dq_d[D_DQ];

	always_ff @(posedge clk) begin
		if (en) begin
			urem_s[0] <= ov0 ? 31'd0 : {2'b00, nu_s[59:31]};
			uq_s[0]   <= '0;
			unl_s[0]  <= nu_s[30:0];
			udq_s[0]  <= dq_d[D_DQ];
			uov_s[0]  <= ov0;
		end
	end

	generate
		for (gj = 0; gj < 31; gj++) begin : g_udiv
			logic [31:0] t;

			assign t = {urem_s[gj], unl_s[gj][30]};

			always_ff @(posedge clk) begin
				if (en) begin
					if (t >= udq_s[gj]) begin
						urem_s[gj+1] <= 31'(t - udq_s[gj]);
						uq_s[gj+1]   <= {uq_s[gj][29:0], 1'b1};
					end else begin
						urem_s[gj+1] <= t[30:0];
						uq_s[gj+1]   <= {uq_s[gj][29:0], 1'b0};
					end
					unl_s[gj+1] <= {unl_s[gj][29:0], 1'b0};
					udq_s[gj+1] <= udq_s[gj];
					uov_s[gj+1] <= uov_s[gj];
				end
			end
		end
	endgenerate

	// Saturate the ratio to one, square it and form 1 - u^2.
	localparam logic [30:0] ONE_U = 31'd1 << 30;

	logic [30:0] u_s;
	logic [61:0] usq_s, usq_p;
	logic [63:0] wv_s;

	assign usq_p = u_s * u_s;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s   <= (uov_s[31] || (uq_s[31] > ONE_U)) ? ONE_U : uq_s[31];
			usq_s <= usq_p;
			wv_s  <= tlik_pkg::ONE_SQ - 64'(usq_s);
		end
	end

	assign sq_in[2] = wv_s;

	logic [30:0] u_d [1:D_U];

	always_ff @(posedge clk) begin
		if (en) begin
			u_d[1] <= u_s;
			for (int i = 2; i <= D_U; i++) begin
				u_d[i] <= u_d[i-1];
			end
		end
	end

	assign cin_y[2] = CDW'(signed'({1'b0, u_d[D_U]}));
	assign cin_x[2] = CDW'(signed'({1'b0, sq_out[2][30:0]}));
	assign cin_y[0] = CDW'(y_s1);
	assign cin_x[0] = CDW'(x_s1);

	// Square root units: floor root of a 64-bit word, one result bit per stage.
	genvar gu;
	generate
		for (gu = 0; gu < 3; gu++) begin : g_sqrt
			logic [33:0] rem_s [0:32];
			logic [31:0] root_s [0:32];
			logic [63:0] val_s [0:32];

			assign rem_s[0]  = '0;
			assign root_s[0] = '0;
			assign val_s[0]  = sq_in[gu];

			for (gj = 0; gj < 32; gj++) begin : g_step
				logic [35:0] r2, trial;

				assign r2    = {rem_s[gj], val_s[gj][63:62]};
				assign trial = {2'b00, root_s[gj], 2'b01};

				always_ff @(posedge clk) begin
					if (en) begin
						if (r2 >= trial) begin
							rem_s[gj+1]  <= 34'(r2 - trial);
							root_s[gj+1] <= {root_s[gj][30:0], 1'b1};
						end else begin
							rem_s[gj+1]  <= r2[33:0];
							root_s[gj+1] <= {root_s[gj][30:0], 1'b0};
						end
						val_s[gj+1] <= {val_s[gj][61:0], 2'b00};
					end
				end
			end

			assign sq_out[gu] = root_s[32];
		end
	endgenerate

	// CORDIC vectoring units: quadrant fold, normalize, then thirty rotations.
	generate
		for (gu = 0; gu < 3; gu++) begin : g_cordic
			logic signed [CDW-1:0] x_p1, y_p1, x_p2, y_p2;
			logic signed [ZW-1:0]  z_p1, z_p2;
			logic                  zf_p1, zf_p2;
			logic [4:0]            sh_p2, sh_c;
			logic [CDW-1:0]        mx, my;
			logic [28:0]           mo;
			logic signed [CDW-1:0] xs [0:NS];
			logic signed [CDW-1:0] ys [0:NS];
			logic signed [ZW-1:0]  zs [0:NS];
			logic                  zf [0:NS];

			// Fold the left half plane onto the right one.
			always_ff @(posedge clk) begin
				if (en) begin
					zf_p1 <= (cin_x[gu] == '0) && (cin_y[gu] == '0);
					if (cin_x[gu] < 0) begin
						x_p1 <= -cin_x[gu];
						y_p1 <= -cin_y[gu];
						z_p1 <= (cin_y[gu] >= 0) ? tlik_pkg::PI_Q : -tlik_pkg::PI_Q;
					end else begin
						x_p1 <= cin_x[gu];
						y_p1 <= cin_y[gu];
						z_p1 <= '0;
					end
				end
			end

			// Find the shift that brings the larger magnitude up to 2^29.
			always_comb begin
				mx   = x_p1;
				my   = y_p1[CDW-1] ? CDW'(-y_p1) : y_p1;
				mo   = mx[28:0] | my[28:0];
				sh_c = '0;
				for (int j = 0; j < 29; j++) begin
					if (mo[j]) begin
						sh_c = 5'(29 - j);
					end
				end
				if (((mx >> 29) != '0) || ((my >> 29) != '0)) begin
					sh_c = '0;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_p2  <= x_p1;
					y_p2  <= y_p1;
					z_p2  <= z_p1;
					zf_p2 <= zf_p1;
					sh_p2 <= sh_c;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					xs[0] <= x_p2 <<< sh_p2;
					ys[0] <= y_p2 <<< sh_p2;
					zs[0] <= z_p2;
					zf[0] <= zf_p2;
				end
			end

			for (gj = 0; gj < NS; gj++) begin : g_rot
				always_ff @(posedge clk) begin
					if (en) begin
						if (ys[gj] > 0) begin
							xs[gj+1] <= xs[gj] + (ys[gj] >>> gj);
							ys[gj+1] <= ys[gj] - (xs[gj] >>> gj);
							zs[gj+1] <= zs[gj] + tlik_pkg::ATAN_TAB[gj];
						end else begin
							xs[gj+1] <= xs[gj] - (ys[gj] >>> gj);
							ys[gj+1] <= ys[gj] + (xs[gj] >>> gj);
							zs[gj+1] <= zs[gj] - tlik_pkg::ATAN_TAB[gj];
						end
						zf[gj+1] <= zf[gj];
					end
				end
			end

			assign cz[gu] = zf[NS] ? '0 : zs[NS];
		end
	endgenerate

	// Align theta, beta and the flags with gamma.
	logic signed [ZW-1:0] th_d [1:D_TH];
	logic signed [ZW-1:0] bt_d [1:D_BT];
	logic                 zd_d [1:D_ZD];
	logic                 rf_d [1:D_RF];

	always_ff @(posedge clk) begin
		if (en) begin
			th_d[1] <= cz[0];
			bt_d[1] <= cz[1];
			zd_d[1] <= zd_s4;
			rf_d[1] <= sat_s4 || zd_s4;
			for (int i = 2; i <= D_TH; i++) begin
				th_d[i] <= th_d[i-1];
			end
			for (int i = 2; i <= D_BT; i++) begin
				bt_d[i] <= bt_d[i-1];
			end
			for (int i = 2; i <= D_ZD; i++) begin
				zd_d[i] <= zd_d[i-1];
			end
			for (int i = 2; i <= D_RF; i++) begin
				rf_d[i] <= rf_d[i-1];
			end
		end
	end

	// Joint angles in Q30.
	logic signed [OW-1:0] shd_s, eld_s;

	always_ff @(posedge clk) begin
		if (en) begin
			shd_s <= OW'(th_d[D_TH]) - (zd_d[D_ZD] ? OW'(0) : OW'(cz[2]));
			eld_s <= OW'(tlik_pkg::PI_Q) - OW'(bt_d[D_BT]);
		end
	end

	// Round to the output format, half away from zero.
	localparam logic [OW-1:0] HALF = OW'(1) << (RS - 1);

	logic [OW-1:0]        shm, elm, shr_u, elr_u;
	logic signed [OW-1:0] shr_s, elr_s;

	assign shm   = shd_s[OW-1] ? OW'(-shd_s) : shd_s;
	assign elm   = eld_s[OW-1] ? OW'(-eld_s) : eld_s;
	assign shr_u = (shm + HALF) >> RS;
	assign elr_u = (elm + HALF) >> RS;

	always_ff @(posedge clk) begin
		if (en) begin
			shr_s <= shd_s[OW-1] ? -signed'(shr_u) : signed'(shr_u);
			elr_s <= eld_s[OW-1] ? -signed'(elr_u) : signed'(elr_u);
		end
	end

	// Clamp to the limits; the lower limit is checked first.
	logic signed [OW-1:0] sh_lo, sh_hi, el_lo, el_hi;

	assign sh_lo = OW'(sh_min_q);
	assign sh_hi = OW'(sh_max_q);
	assign el_lo = OW'(el_min_q);
	assign el_hi = OW'(el_max_q);

	always_ff @(posedge clk) begin
		if (en) begin
			out_of_reach <= rf_d[D_RF];
			if (shr_s < sh_lo) begin
				shoulder_angle   <= sh_min_q;
				shoulder_clamped <= 1'b1;
			end else if (shr_s > sh_hi) begin
				shoulder_angle   <= sh_max_q;
				shoulder_clamped <= 1'b1;
			end else begin
				shoulder_angle   <= shr_s[15:0];
				shoulder_clamped <= 1'b0;
			end
			if (elr_s < el_lo) begin
				elbow_angle   <= el_min_q;
				elbow_clamped <= 1'b1;
			end else if (elr_s > el_hi) begin
				elbow_angle   <= el_max_q;
				elbow_clamped <= 1'b1;
			end else begin
				elbow_angle   <= elr_s[15:0];
				elbow_clamped <= 1'b0;
			end
		end
	end

endmodule

// ----- sim/two_link_inverse_kinematics_unit_checker.sv -----
// Checker that predicts and compares the joint angles of the inverse kinematics unit.
`timescale 1ns / 1ps

module two_link_inverse_kinematics_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        target_valid,
	input  logic        target_ready,
	input  logic [15:0] target_x,
	input  logic [15:0] target_y,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [15:0] shoulder_angle,
	input  logic [15:0] elbow_angle,
	input  logic        out_of_reach,
	input  logic        shoulder_clamped,
	input  logic        elbow_clamped,
	output int          errors,
	output int          pending
);
	import tlik_pkg::*;

	typedef struct packed {
		logic [15:0] shoulder;
		logic [15:0] elbow;
		logic        unreachable;
		logic        shoulder_lim;
		logic        elbow_lim;
	} joint_angles_t;

	localparam longint HALF_TURN = 64'sd3373259426;
	localparam longint ARCTAN_STEP [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2
	};

	// Local copy of the configuration registers.
	logic [13:0]        arm_len_one, arm_len_two;
	logic signed [15:0] shift_x, shift_y;
	logic signed [15:0] shoulder_lo, shoulder_hi, elbow_lo, elbow_hi;

	joint_angles_t angles_due[$];

	assign pending = angles_due.size();

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? 64'd0 - longint'(v) : v;
	endfunction

	// Vectoring CORDIC arctangent in Q30 radians.
	function automatic longint vector_angle(longint y, longint x);
		longint z;
		longint dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		while (magnitude(x) < (64'd1 << 29) && magnitude(y) < (64'd1 << 29)) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ARCTAN_STEP[i];
			end else begin
				x -= dx; y += dy; z -= ARCTAN_STEP[i];
			end
		end
		return z;
	endfunction

	// Rounds Q30 to Q3.12, half away from zero.
	function automatic longint to_q12(longint v);
		if (v >= 0)
			return longint'((longint'(v) + (64'd1 << 17)) >> 18);
		return -longint'((magnitude(v) + (64'd1 << 17)) >> 18);
	endfunction

	function automatic joint_angles_t solve_arm(logic signed [15:0] tx, logic signed [15:0] ty);
		longint x, y, c, sb, beta, gamma, theta, sh, el;
		longint unsigned l1, l2, ax, ay, d2, ls, den, m, dq, u;
		bit neg;
		int k;
		joint_angles_t r;
		x = longint'(tx) + longint'(shift_x);
		y = longint'(ty) + longint'(shift_y);
		l1 = arm_len_one;
		l2 = arm_len_two;
		ax = magnitude(x);
		ay = magnitude(y);
		d2 = ax * ax + ay * ay;
		ls = l1 * l1 + l2 * l2;
		den = 2 * l1 * l2;
		r.unreachable = 1'b0;
		gamma = 0;
		if (ls >= d2) begin
			m = ls - d2; neg = 1'b0;
		end else begin
			m = d2 - ls; neg = 1'b1;
		end
		// Law of cosines term, saturated when the point is out of reach.
		if (den == 0 || m > den) begin
			c = neg ? -(64'sd1 << 30) : (64'sd1 << 30);
			r.unreachable = 1'b1;
		end else begin
			c = ((m << 30) + den / 2) / den;
			if (neg)
				c = -c;
		end
		sb = floor_root((64'd1 << 60) - longint'(c * c));
		beta = vector_angle(sb, c);
		// Correction angle between the target direction and the first link.
		if (d2 == 0) begin
			r.unreachable = 1'b1;
		end else begin
			k = 15;
			while (k > 0 && (d2 >> (62 - 2 * k)) != 0)
				k--;
			dq = floor_root(d2 << (2 * k));
			u = ((longint'(sb) * l2) << k) / dq;
			if (u > (64'd1 << 30))
				u = 64'd1 << 30;
			gamma = vector_angle(u, floor_root((64'd1 << 60) - u * u));
		end
		theta = vector_angle(y, x);
		sh = to_q12(theta - gamma);
		el = to_q12(HALF_TURN - beta);
		// Limits: the lower one is tested first.
		r.shoulder_lim = 1'b1;
		if (sh < shoulder_lo) sh = shoulder_lo;
		else if (sh > shoulder_hi) sh = shoulder_hi;
		else r.shoulder_lim = 1'b0;
		r.elbow_lim = 1'b1;
		if (el < elbow_lo) el = elbow_lo;
		else if (el > elbow_hi) el = elbow_hi;
		else r.elbow_lim = 1'b0;
		r.shoulder = sh[15:0];
		r.elbow = el[15:0];
		return r;
	endfunction

	// Track configuration writes, predict on each accepted target, check each result.
	always @(posedge clk or negedge arst_n) begin
		joint_angles_t exp_a;
		joint_angles_t got;
		if (!arst_n) begin
			arm_len_one <= RST_LINK;
			arm_len_two <= RST_LINK;
			shift_x <= '0;
			shift_y <= '0;
			shoulder_lo <= RST_ANGLE_MIN;
			shoulder_hi <= RST_ANGLE_MAX;
			elbow_lo <= RST_ANGLE_MIN;
			elbow_hi <= RST_ANGLE_MAX;
			errors <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LINK_ONE:    arm_len_one <= cfg_data[13:0];
					CFG_LINK_TWO:    arm_len_two <= cfg_data[13:0];
					CFG_OFFSET_X:    shift_x <= cfg_data;
					CFG_OFFSET_Y:    shift_y <= cfg_data;
					CFG_SHOULDER_LO: shoulder_lo <= cfg_data;
					CFG_SHOULDER_HI: shoulder_hi <= cfg_data;
					CFG_ELBOW_LO:    elbow_lo <= cfg_data;
					CFG_ELBOW_HI:    elbow_hi <= cfg_data;
					default: ;
				endcase
			end
			if (target_valid && target_ready)
				angles_due.push_back(solve_arm(target_x, target_y));
			if (result_valid && result_ready) begin
				got = '{shoulder_angle, elbow_angle, out_of_reach, shoulder_clamped,
					elbow_clamped};
				if (angles_due.size() == 0) begin
					if (errors < 10)
						$display("result transaction with nothing expected: %p", got);
					errors <= errors + 1;
				end else begin
					exp_a = angles_due.pop_front();
					if (got !== exp_a) begin
						if (errors < 10)
							$display("mismatch: expected %p, got %p", exp_a, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ----- sim/two_link_inverse_kinematics_unit_test.sv -----
// Testbench top: drives targets and configuration into the unit and gives the verdict.
`timescale 1ns / 1ps

module two_link_inverse_kinematics_unit_test;
	import tlik_pkg::*;

	localparam int LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        target_valid;
	logic        target_ready;
	logic signed [15:0] target_x, target_y;
	logic        result_valid;
	logic        result_ready;
	logic signed [15:0] shoulder_angle, elbow_angle;
	logic        out_of_reach, shoulder_clamped, elbow_clamped;
	int          errors, pending;
	int          cycles;
	bit          quiet;
	int          stall_left;
	int          reach;

	two_link_inverse_kinematics_unit u_top (.*);

	two_link_inverse_kinematics_unit_checker u_checker (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data, .target_valid, .target_ready,
		.target_x, .target_y, .result_valid, .result_ready, .shoulder_angle,
		.elbow_angle, .out_of_reach, .shoulder_clamped, .elbow_clamped, .errors, .pending
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Cycle limit in case the unit stops responding.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("two_link_inverse_kinematics_unit_test: errors");
			$finish;
		end
	end

	// Receiver stalls in random bursts.
	initial stall_left = 0;
	always @(negedge clk) begin
		if (quiet || stall_left == 0) begin
			result_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0)
				stall_left <= $urandom_range(1, 12);
		end else begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end
	end

	// One target transaction, with an occasional idle burst ahead of it.
	task automatic send_target(logic [15:0] tx, logic [15:0] ty);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			target_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		target_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		do @(posedge clk); while (!target_ready);
		@(negedge clk);
	endtask

	// Let the pipeline empty before touching the registers.
	task automatic drain();
		target_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Targets mostly near the workspace, shifted back by the offsets.
	task automatic random_targets(int count, int offx, int offy);
		int tx, ty;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				tx = $urandom;
				ty = $urandom;
			end else begin
				tx = int'($urandom_range(0, 2 * reach)) - reach - offx;
				ty = int'($urandom_range(0, 2 * reach)) - reach - offy;
			end
			send_target(tx[15:0], ty[15:0]);
		end
	endtask

	task automatic set_arm(int l1, int l2, int ox, int oy, int slo, int shi, int elo,
		int ehi);
		drain();
		write_reg(CFG_LINK_ONE, l1[15:0]);
		write_reg(CFG_LINK_TWO, l2[15:0]);
		write_reg(CFG_OFFSET_X, ox[15:0]);
		write_reg(CFG_OFFSET_Y, oy[15:0]);
		write_reg(CFG_SHOULDER_LO, slo[15:0]);
		write_reg(CFG_SHOULDER_HI, shi[15:0]);
		write_reg(CFG_ELBOW_LO, elo[15:0]);
		write_reg(CFG_ELBOW_HI, ehi[15:0]);
		reach = l1 + l2 + 1;
	endtask

	initial begin
		int l1, l2, ox, oy;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		target_valid = 1'b0;
		target_x = '0;
		target_y = '0;
		result_ready = 1'b0;
		quiet = 1'b0;
		reach = 3201;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed points under the reset configuration.
		send_target(16'sd0, 16'sd0);
		send_target(16'sd3200, 16'sd0);
		send_target(-16'sd3200, 16'sd0);
		send_target(-16'sd100, 16'sd0);
		send_target(16'sd0, 16'sd3200);
		send_target(16'sd0, -16'sd3200);
		send_target(16'sd32767, 16'sd32767);
		send_target(-16'sd32768, -16'sd32768);
		send_target(-16'sd32768, 16'sd32767);
		send_target(16'sd1, 16'sd0);
		send_target(16'sd1600, 16'sd1600);
		send_target(16'sd2262, 16'sd0);
		send_target(16'sd3201, 16'sd0);
		send_target(16'h5555, 16'haaaa);
		send_target(16'haaaa, 16'h5555);

		// Extreme lengths and offsets, reversed and narrow limits.
		set_arm(16383, 16383, 32767, -32768, 19303, -19303, 100, 100);
		send_target(16'sd0, 16'sd0);
		send_target(-16'sd32767, 16'sd32767);
		send_target(16'sd32767, 16'sd0);
		set_arm(1, 1, -32768, 32767, -19303, 19303, -19303, 19303);
		send_target(16'sd32767, -16'sd32767);
		send_target(16'sd32769, -16'sd32768);
		send_target(16'sd32767, -16'sd32766);
		set_arm(0, 500, 0, 0, -4096, 4096, 0, 8192);
		send_target(16'sd400, 16'sd300);
		send_target(16'sd0, 16'sd0);
		set_arm(16383, 1, 0, 0, -19303, 19303, -19303, 19303);
		send_target(16'sd16383, 16'sd0);
		send_target(16'sd16382, 16'sd1);

		// Random phases, each with its own random configuration.
		for (int phase = 0; phase < 8; phase++) begin
			l1 = $urandom_range(1, (phase % 2) ? 16383 : 4000);
			l2 = $urandom_range(1, (phase % 2) ? 16383 : 4000);
			ox = int'($urandom_range(0, 8000)) - 4000;
			oy = int'($urandom_range(0, 8000)) - 4000;
			set_arm(l1, l2, ox, oy, -int'($urandom_range(0, 19303)),
				$urandom_range(0, 19303), $urandom_range(0, 6000),
				$urandom_range(6000, 19303));
			random_targets(45, ox, oy);
			drain();
			random_targets(45, ox, oy);
		end
		set_arm(1600, 1600, 0, 0, -19303, 19303, -19303, 19303);
		random_targets(60, 0, 0);
		quiet = 1'b1;
		random_targets(70, 0, 0);

		drain();
		if (errors == 0)
			$display("two_link_inverse_kinematics_unit_test: clean");
		else
			$display("two_link_inverse_kinematics_unit_test: errors");
		$finish;
	end

endmodule
